>>> rtl/rsmc_pkg.sv
package rsmc_pkg;

   localparam int ANGLE_W = 12;
   localparam int WIDE_W  = 14;
   localparam int DUTY_W  = 8;
   localparam int MODE_W  = 3;

   localparam logic signed [WIDE_W-1:0] ANGLE_MAX = 14'sd1800;

   localparam logic [10:0] DEADMAN_LIMIT = 11'd1000;
   localparam logic [DUTY_W-1:0] FINE_STEP = 8'd15;

   localparam logic signed [11:0] TILLER_ZERO      = 12'sd170;
   localparam logic signed [11:0] TILLER_MID_ANGLE = 12'sd450;
   // 450/821 scaled by 2^24, rounded up; exact for magnitudes below 2048
   localparam logic [34:0] TILLER_RECIP = 35'd9195795;
   localparam int TILLER_SHIFT = 24;

   localparam logic [4:0] HEADING_ERR_MAX = 5'd20;

   localparam logic signed [WIDE_W-1:0] COARSE_BAND   = 14'sd100;
   localparam logic signed [WIDE_W-1:0] DEAD_BAND     = 14'sd10;
   localparam logic signed [WIDE_W-1:0] COARSE_LIMIT  = 14'sd500;
   localparam logic signed [WIDE_W-1:0] FINE_LIMIT    = 14'sd550;
   localparam logic signed [WIDE_W-1:0] END_STOP      = 14'sd650;

   typedef enum logic [1:0] {
      OP_NONE       = 2'd0,
      OP_LOAD_MODE  = 2'd1,
      OP_LOAD_ANGLE = 2'd2,
      OP_LOAD_PRESET = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      RCMD_NONE    = 2'd0,
      RCMD_RUDDER  = 2'd1,
      RCMD_HEADING = 2'd2,
      RCMD_UNUSED  = 2'd3
   } remote_cmd_type;

   localparam logic [MODE_W-1:0] MODE_STANDBY        = 3'd0;
   localparam logic [MODE_W-1:0] MODE_RADIO          = 3'd1;
   localparam logic [MODE_W-1:0] MODE_BUS            = 3'd2;
   localparam logic [MODE_W-1:0] MODE_REMOTE_RUDDER  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_LOCAL_RUDDER   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_REMOTE_HEADING = 3'd5;
   localparam logic [MODE_W-1:0] MODE_LOCAL_HEADING  = 3'd6;
   localparam logic [MODE_W-1:0] MODE_PRESET         = 3'd7;

   localparam logic [2:0] BUS_DIR_CONTROL = 3'd1;

   localparam logic CSR_FULL_DUTY    = 1'b0;
   localparam logic CSR_OWN_INSTANCE = 1'b1;

   localparam logic [DUTY_W-1:0] FULL_DUTY_RESET    = 8'd45;
   localparam logic [7:0]        OWN_INSTANCE_RESET = 8'd10;

   function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [WIDE_W-1:0] a);
      logic signed [ANGLE_W-1:0] r;
      if (a > ANGLE_MAX) begin
         r = ANGLE_W'(ANGLE_MAX);
      end else if (a < -ANGLE_MAX) begin
         r = ANGLE_W'(-ANGLE_MAX);
      end else begin
         r = ANGLE_W'(a);
      end
      return r;
   endfunction

endpackage

>>> rtl/rudder_steering_mode_controller.sv
// Rudder steering mode controller. Takes sensor/command words and returns one result word
// per input word, through an input register (where the tiller scaling multiply and the
// position clamp are done) and a result register that also updates the mode, angle order,
// preset and duty state. Sustained rate is one word per cycle while rsp_stall is low; the
// controller state feeds the very next word, so consecutive words see each other's updates
// in order. Duties hold their last value when no steering rule applies; drive_enable is low
// in standby. The user writes full_duty and own_instance through the csr port while no word
// is in flight; the block does not enforce this.
module rudder_steering_mode_controller (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [11:0]          req_rudder_position,
   input  logic signed [9:0]           req_heading_deg,
   input  logic signed [8:0]           req_heading_target,
   input  logic [10:0]                 req_tiller_channel,
   input  logic [10:0]                 req_deadman_channel,
   input  logic                        req_feedback_valid,
   input  logic [7:0]                  req_bus_instance,
   input  logic [2:0]                  req_bus_direction,
   input  logic [1:0]                  req_remote_command,
   input  logic signed [10:0]          req_remote_angle,
   input  logic [1:0]                  req_opcode,
   input  logic signed [11:0]          req_panel_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_drive_enable,
   output logic [7:0]                  rsp_starboard_duty,
   output logic [7:0]                  rsp_port_duty,
   output logic [2:0]                  rsp_mode_now,
   output logic signed [11:0]          rsp_angle_target,
   input  logic                        csr_write_enable,
   input  logic                        csr_index,
   input  logic [7:0]                  csr_write_data
);
   import rsmc_pkg::*;

   // configuration
   logic [DUTY_W-1:0] full_duty_ff;
   logic [7:0]        own_instance_ff;

   // input register
   logic                      s1_valid_ff;
   logic signed [ANGLE_W-1:0] s1_pos_ff;
   logic signed [9:0]         s1_hdg_ff;
   logic signed [8:0]         s1_tgt_ff;
   logic signed [ANGLE_W-1:0] s1_tiller_ff;
   logic                      s1_radio_ff;
   logic                      s1_fb_ff;
   logic [7:0]                s1_inst_ff;
   logic                      s1_bus_dir_ff;
   logic [1:0]                s1_rcmd_ff;
   logic signed [10:0]        s1_rang_ff;
   logic [1:0]                s1_op_ff;
   logic signed [11:0]        s1_pval_ff;

   // controller state
   logic [MODE_W-1:0]         mode_ff, mode_in;
   logic signed [ANGLE_W-1:0] angle_ff, angle_in;
   logic                      armed_ff, armed_in;
   logic [DUTY_W-1:0]         stbd_ff, stbd_in;
   logic [DUTY_W-1:0]         port_ff, port_in;

   // result register
   logic rsp_valid_ff;
   logic enable_ff, enable_in;

   logic out_free;
   logic advance;
   logic accept;

   logic signed [11:0]  tl_diff;
   logic [10:0]         tl_mag;
   logic [34:0]         tl_prod;
   logic [10:0]         tl_quot;
   logic signed [11:0]  tl_signed;
   logic signed [11:0]  tl_angle;

   logic signed [10:0]        hdg_diff;
   logic [9:0]                err_mag;
   logic [4:0]                err_clamp;
   logic signed [WIDE_W-1:0]  err_tenths;
   logic [DUTY_W-1:0]         fine_duty;
   logic signed [WIDE_W-1:0]  a_w;
   logic signed [WIDE_W-1:0]  p_w;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   // tiller scaling: trunc((t - 170) * 900 / 1642) - 450
   always_comb begin
      tl_diff   = $signed({1'b0, req_tiller_channel}) - TILLER_ZERO;
      tl_mag    = tl_diff[11] ? 11'(-tl_diff) : tl_diff[10:0];
      tl_prod   = 35'(tl_mag) * TILLER_RECIP;
      tl_quot   = tl_prod[TILLER_SHIFT +: 11];
      tl_signed = tl_diff[11] ? -$signed({1'b0, tl_quot}) : $signed({1'b0, tl_quot});
      tl_angle  = tl_signed - TILLER_MID_ANGLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pos_ff     <= sat_angle(WIDE_W'(req_rudder_position));
         s1_hdg_ff     <= req_heading_deg;
         s1_tgt_ff     <= req_heading_target;
         s1_tiller_ff  <= tl_angle;
         s1_radio_ff   <= req_deadman_channel > DEADMAN_LIMIT;
         s1_fb_ff      <= req_feedback_valid;
         s1_inst_ff    <= req_bus_instance;
         s1_bus_dir_ff <= req_bus_direction == BUS_DIR_CONTROL;
         s1_rcmd_ff    <= req_remote_command;
         s1_rang_ff    <= req_remote_angle;
         s1_op_ff      <= req_opcode;
         s1_pval_ff    <= req_panel_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_duty_ff    <= FULL_DUTY_RESET;
         own_instance_ff <= OWN_INSTANCE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FULL_DUTY:    full_duty_ff    <= csr_write_data;
            CSR_OWN_INSTANCE: own_instance_ff <= csr_write_data;
            default:          full_duty_ff    <= full_duty_ff;
         endcase
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      angle_in  = angle_ff;
      armed_in  = armed_ff;
      stbd_in   = stbd_ff;
      port_in   = port_ff;
      enable_in = 1'b1;
      fine_duty = (full_duty_ff >= FINE_STEP) ? full_duty_ff - FINE_STEP : '0;

      case (opcode_type'(s1_op_ff))
         OP_LOAD_MODE: begin
            mode_in  = s1_pval_ff[MODE_W-1:0];
            armed_in = 1'b0;
         end
         OP_LOAD_ANGLE: begin
            angle_in = sat_angle(WIDE_W'(s1_pval_ff));
         end
         OP_LOAD_PRESET: begin
            angle_in = sat_angle(WIDE_W'(s1_pval_ff));
            armed_in = 1'b1;
         end
         default: begin
            armed_in = armed_in;
         end
      endcase

      // heading hold
      hdg_diff   = 11'(s1_hdg_ff) - 11'(s1_tgt_ff);
      err_mag    = hdg_diff[10] ? 10'(-hdg_diff) : hdg_diff[9:0];
      err_clamp  = (err_mag > 10'(HEADING_ERR_MAX)) ? HEADING_ERR_MAX : err_mag[4:0];
      err_tenths = $signed(WIDE_W'({err_clamp, 3'b000})) + $signed(WIDE_W'({err_clamp, 1'b0}));
      if (mode_in inside {MODE_REMOTE_HEADING, MODE_LOCAL_HEADING}) begin
         if (hdg_diff > 11'sd1) begin
            angle_in = sat_angle(WIDE_W'(s1_pos_ff) - err_tenths);
         end else if (hdg_diff < -11'sd1) begin
            angle_in = sat_angle(WIDE_W'(s1_pos_ff) + err_tenths);
         end else if (hdg_diff == 11'sd0) begin
            angle_in = s1_pos_ff;
         end
      end

      // source priority
      if (s1_radio_ff && s1_fb_ff) begin
         angle_in = s1_tiller_ff;
         mode_in  = MODE_RADIO;
      end else if (s1_inst_ff == own_instance_ff && s1_bus_dir_ff && s1_fb_ff) begin
         mode_in = MODE_BUS;
      end else if (s1_fb_ff && ((mode_in inside {MODE_LOCAL_RUDDER, MODE_LOCAL_HEADING}) ||
                                (mode_in == MODE_PRESET && armed_in))) begin
         mode_in = mode_in;
      end else if (s1_rcmd_ff == RCMD_RUDDER) begin
         angle_in = sat_angle(WIDE_W'(s1_rang_ff));
         mode_in  = MODE_REMOTE_RUDDER;
      end else if (s1_rcmd_ff == RCMD_HEADING) begin
         mode_in = MODE_REMOTE_HEADING;
      end else begin
         enable_in = 1'b0;
      end

      // bang-bang steering
      a_w = WIDE_W'(angle_in);
      p_w = WIDE_W'(s1_pos_ff);
      if (a_w > p_w + COARSE_BAND && p_w < COARSE_LIMIT) begin
         port_in = '0;
         stbd_in = full_duty_ff;
      end
      if (a_w <= p_w + COARSE_BAND && a_w >= p_w + DEAD_BAND && p_w < FINE_LIMIT) begin
         port_in = '0;
         stbd_in = fine_duty;
      end
      if (a_w < p_w - COARSE_BAND && p_w > -COARSE_LIMIT) begin
         stbd_in = '0;
         port_in = full_duty_ff;
      end
      if (a_w >= p_w - COARSE_BAND && a_w <= p_w - DEAD_BAND && p_w > -FINE_LIMIT) begin
         stbd_in = '0;
         port_in = fine_duty;
      end
      if ((a_w < p_w && p_w <= -END_STOP) ||
          (p_w - DEAD_BAND < a_w && a_w < p_w + DEAD_BAND) ||
          (a_w > p_w && p_w > END_STOP)) begin
         stbd_in = '0;
         port_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_STANDBY;
         angle_ff <= '0;
         armed_ff <= 1'b0;
         stbd_ff  <= '0;
         port_ff  <= '0;
      end else if (advance) begin
         mode_ff  <= mode_in;
         angle_ff <= angle_in;
         armed_ff <= armed_in;
         stbd_ff  <= stbd_in;
         port_ff  <= port_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         enable_ff <= enable_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_drive_enable   = enable_ff;
   assign rsp_starboard_duty = stbd_ff;
   assign rsp_port_duty      = port_ff;
   assign rsp_mode_now       = mode_ff;
   assign rsp_angle_target   = angle_ff;

endmodule
